// File: rtl/wsd_pkg.sv
package wsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W    = 64;
    localparam int KEY_W    = 32;
    localparam int EXTCNT_W = 4;
    localparam int KPOS_W   = 2;
    localparam int PHASE_W  = 3;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_HDR0   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR1   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXTLEN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_KEY    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA   = 3'd4;

    // opcodes that get a flag
    localparam logic [OPCODE_W-1:0] OP_CONT  = 4'h0;
    localparam logic [OPCODE_W-1:0] OP_CLOSE = 4'h8;
    localparam logic [OPCODE_W-1:0] OP_PING  = 4'h9;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // extended length / key byte counts
    localparam logic [EXTCNT_W-1:0] EXT_BYTES_16 = 4'd2;
    localparam logic [EXTCNT_W-1:0] EXT_BYTES_64 = 4'd8;
    localparam logic [EXTCNT_W-1:0] KEY_BYTES    = 4'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              data_valid;
        logic              is_final;
        logic              is_ping;
        logic              is_continuation;
        logic              is_close;
        logic              frame_end;
    } res_t;

endpackage

// File: rtl/websocket_frame_deframer_core.sv
// WebSocket (RFC 6455) frame deframer.
// Input channel: in_valid / in_stall / in_byte, one raw stream byte per word.
// Output channel: out_valid / out_stall plus out_byte, data_valid, is_final,
//   is_ping, is_continuation, is_close and frame_end, one word per payload
//   byte. A zero-length frame gives a single word with data_valid low,
//   out_byte zero and frame_end high. Header, extended length and key bytes
//   give no output word.
// Payload bytes come out unmasked (XOR with the key byte at index mod 4).
// Path: an accepted word passes the input register, then the result register.
// Throughput: one byte per cycle, sustained while out_stall does not hold
//   the flow; the only loop is the parse state update (64-bit length decrement).
// Stall: while out_stall holds a waiting result, the input register keeps
//   one more byte and in_stall rises only when that register is also full.
// Reset (rst_n low, async): both registers empty, parser back to the first
//   header byte, all frame state cleared.
module websocket_frame_deframer_core
    import wsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              data_valid,
    output logic              is_final,
    output logic              is_ping,
    output logic              is_continuation,
    output logic              is_close,
    output logic              frame_end
);

    logic              down_ready;
    logic              step;
    logic [BYTE_W-1:0] byte_q;
    logic              res_valid;
    res_t              res;
    res_t              res_q;

    wsd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .down_ready (down_ready),
        .step       (step),
        .byte_q     (byte_q)
    );

    wsd_parser u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (byte_q),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register loads only when the parser actually makes a word
    wsd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res_in    (res),
        .out_stall (out_stall),
        .ready     (down_ready),
        .out_valid (out_valid),
        .res_q     (res_q)
    );

    assign out_byte        = res_q.data;
    assign data_valid      = res_q.data_valid;
    assign is_final        = res_q.is_final;
    assign is_ping         = res_q.is_ping;
    assign is_continuation = res_q.is_continuation;
    assign is_close        = res_q.is_close;
    assign frame_end       = res_q.frame_end;

endmodule

// File: rtl/wsd_in_stage.sv
module wsd_in_stage
    import wsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              down_ready,
    output logic              step,
    output logic [BYTE_W-1:0] byte_q
);

    logic              vld_reg;
    logic              vld_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    // the held word moves on when the result register can take whatever it makes
    assign step     = vld_reg && down_ready;
    assign in_stall = vld_reg && !down_ready;
    assign take     = in_valid && !in_stall;
    assign byte_q   = byte_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (step)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

// File: rtl/wsd_parser.sv
module wsd_parser
    import wsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] byte_in,
    output logic              res_valid,
    output res_t              res
);

    logic [PHASE_W-1:0]  phase_reg,  phase_next;
    logic                final_reg,  final_next;
    logic [OPCODE_W-1:0] opcode_reg, opcode_next;
    logic                masked_reg, masked_next;
    logic [LEN_W-1:0]    rem_reg,    rem_next;
    logic [EXTCNT_W-1:0] ext_reg,    ext_next;
    logic [KEY_W-1:0]    key_reg,    key_next;
    logic [KPOS_W-1:0]   kpos_reg,   kpos_next;

    logic [EXTCNT_W-1:0] ext_dec;
    logic [LEN_W-1:0]    rem_dec;
    logic [BYTE_W-1:0]   key_byte;
    logic [6:0]          len_code;
    logic                hdr_done;
    logic                pay_enter;

    assign ext_dec  = (ext_reg != '0) ? ext_reg - 4'd1 : ext_reg;
    assign rem_dec  = (rem_reg != '0) ? rem_reg - 64'd1 : rem_reg;
    assign len_code = byte_in[6:0];

    always_comb
    begin
        case (kpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        final_next  = final_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        rem_next    = rem_reg;
        ext_next    = ext_reg;
        key_next    = key_reg;
        kpos_next   = kpos_reg;
        hdr_done    = 1'b0;
        pay_enter   = 1'b0;
        res_valid   = 1'b0;

        res.data            = '0;
        res.data_valid      = 1'b0;
        res.is_final        = final_reg;
        res.is_ping         = (opcode_reg == OP_PING);
        res.is_continuation = (opcode_reg == OP_CONT);
        res.is_close        = (opcode_reg == OP_CLOSE);
        res.frame_end       = 1'b0;

        case (phase_reg)
            PH_HDR0:
            begin
                final_next  = byte_in[7];
                opcode_next = byte_in[OPCODE_W-1:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                masked_next = byte_in[7];
                key_next    = '0;
                if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64)
                begin
                    rem_next   = '0;
                    ext_next   = (len_code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    rem_next = {{(LEN_W-7){1'b0}}, len_code};
                    hdr_done = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                rem_next = {rem_reg[LEN_W-BYTE_W-1:0], byte_in};
                ext_next = ext_dec;
                hdr_done = (ext_dec == '0);
            end
            PH_KEY:
            begin
                key_next  = {key_reg[KEY_W-BYTE_W-1:0], byte_in};
                ext_next  = ext_dec;
                pay_enter = (ext_dec == '0);
            end
            PH_DATA:
            begin
                kpos_next      = kpos_reg + 2'd1;
                rem_next       = rem_dec;
                res_valid      = 1'b1;
                res.data       = masked_reg ? (byte_in ^ key_byte) : byte_in;
                res.data_valid = 1'b1;
                res.frame_end  = (rem_dec == '0);
                if (rem_dec == '0)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase

        // header complete: key bytes follow if masked
        if (hdr_done)
        begin
            if (masked_next)
            begin
                ext_next   = KEY_BYTES;
                phase_next = PH_KEY;
            end
            else
            begin
                pay_enter = 1'b1;
            end
        end

        // payload entry: zero length gives a flag-only word that ends the frame at once, else data follows
        if (pay_enter)
        begin
            kpos_next = '0;
            if (rem_next == '0)
            begin
                res_valid     = 1'b1;
                res.frame_end = 1'b1;
                phase_next    = PH_HDR0;
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            final_reg  <= 1'b0;
            opcode_reg <= '0;
            masked_reg <= 1'b0;
            rem_reg    <= '0;
            ext_reg    <= '0;
            key_reg    <= '0;
            kpos_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            final_reg  <= final_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            rem_reg    <= rem_next;
            ext_reg    <= ext_next;
            key_reg    <= key_next;
            kpos_reg   <= kpos_next;
        end
    end

endmodule

// File: rtl/wsd_out_stage.sv
module wsd_out_stage
    import wsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t res_in,
    input  logic out_stall,
    output logic ready,
    output logic out_valid,
    output res_t res_q
);

    logic vld_reg;
    logic vld_next;
    res_t res_reg;

    assign ready     = !vld_reg || !out_stall;
    assign out_valid = vld_reg;
    assign res_q     = res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

// File: rtl/wsd_checker.sv
module wsd_checker
    import wsd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [BYTE_W-1:0] out_byte,
    input logic              data_valid,
    input logic              is_ping,
    input logic              is_continuation,
    input logic              is_close,
    input logic              frame_end
);

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(frame_end))
        else $error("stalled output word changed");

    // empty-frame word: zero data, always ends the frame
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_valid |-> out_byte == '0 && frame_end)
        else $error("flag-only word malformed");

    // opcode flags are mutually exclusive
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({is_ping, is_continuation, is_close}))
        else $error("more than one opcode flag set");

    // input side stalls only while a result is waiting downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (.*);

// File: dv/websocket_frame_deframer_core_tb.sv
`timescale 1ns / 1ps

module websocket_frame_deframer_core_tb;
    import wsd_pkg::*;

    // how the payload length is encoded in the header
    localparam int FORM_SHORT = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    // no word accepted on either side for this many cycles means a hang;
    // the longest legal quiet stretch is the receiver hold-off below
    localparam int HANG_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_GAP      = 6;
    localparam int DRAIN_CYCLES = 8;

    logic              clk             = 1'b0;
    logic              rst_n           = 1'b0;
    logic              in_valid        = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] in_byte         = '0;
    logic              out_valid;
    logic              out_stall       = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              data_valid;
    logic              is_final;
    logic              is_ping;
    logic              is_continuation;
    logic              is_close;
    logic              frame_end;

    // Scoreboard: unmasked words still owed by the block, oldest first.
    res_t expected_words[$];
    int   errors     = 0;
    int   bytes_sent = 0;
    bit   idle_on    = 1'b0;
    bit   hold_rx    = 1'b0;
    int   stall_left = 0;
    int   quiet_cycles = 0;

    // Shadow copy of the parser state, updated once per accepted stream byte.
    logic [PHASE_W-1:0]  sh_phase    = PH_HDR0;
    logic                sh_fin      = 1'b0;
    logic [OPCODE_W-1:0] sh_opcode   = '0;
    logic                sh_masked   = 1'b0;
    logic [LEN_W-1:0]    sh_len_left = '0;
    logic [EXTCNT_W-1:0] sh_hdr_left = '0;
    logic [KEY_W-1:0]    sh_key      = '0;
    logic [KPOS_W-1:0]   sh_kpos     = '0;

    websocket_frame_deframer_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_byte         (in_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .data_valid      (data_valid),
        .is_final        (is_final),
        .is_ping         (is_ping),
        .is_continuation (is_continuation),
        .is_close        (is_close),
        .frame_end       (frame_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Queue one output word; flags always follow the held opcode.
    task automatic push_word(input logic [BYTE_W-1:0] data, input logic valid,
                             input logic last);
        res_t w;
        w.data            = data;
        w.data_valid      = valid;
        w.is_final        = sh_fin;
        w.is_ping         = (sh_opcode == OP_PING);
        w.is_continuation = (sh_opcode == OP_CONT);
        w.is_close        = (sh_opcode == OP_CLOSE);
        w.frame_end       = last;
        expected_words = {expected_words, w};
    endtask

    // Header fully read: empty frame gives a flag-only word right away.
    task automatic start_payload();
        sh_kpos = '0;
        if (sh_len_left == '0)
        begin
            push_word('0, 1'b0, 1'b1);
            sh_phase = PH_HDR0;
        end
        else
        begin
            sh_phase = PH_DATA;
        end
    endtask

    // Length known: masked frames still owe four key bytes.
    task automatic finish_length();
        if (sh_masked)
        begin
            sh_hdr_left = KEY_BYTES;
            sh_phase    = PH_KEY;
        end
        else
        begin
            start_payload();
        end
    endtask

    task automatic predict_deframe(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] kbyte;
        logic              last;
        case (sh_phase)
            PH_HDR0:
            begin
                sh_fin    = b[7];
                sh_opcode = b[3:0];
                sh_phase  = PH_HDR1;
            end
            PH_HDR1:
            begin
                sh_masked   = b[7];
                sh_key      = '0;
                sh_len_left = '0;
                if (b[6:0] == LEN_CODE_16 || b[6:0] == LEN_CODE_64)
                begin
                    sh_hdr_left = (b[6:0] == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
                    sh_phase    = PH_EXTLEN;
                end
                else
                begin
                    sh_len_left = LEN_W'(b[6:0]);
                    finish_length();
                end
            end
            PH_EXTLEN:
            begin
                // big-endian, shifted in a byte at a time
                sh_len_left = {sh_len_left[LEN_W-9:0], b};
                if (sh_hdr_left != '0)
                    sh_hdr_left = sh_hdr_left - 1'b1;
                if (sh_hdr_left == '0)
                    finish_length();
            end
            PH_KEY:
            begin
                sh_key = {sh_key[KEY_W-9:0], b};
                if (sh_hdr_left != '0)
                    sh_hdr_left = sh_hdr_left - 1'b1;
                if (sh_hdr_left == '0)
                    start_payload();
            end
            PH_DATA:
            begin
                // first key byte sits in the top bits
                kbyte   = sh_masked ? BYTE_W'(sh_key >> (8 * (3 - int'(sh_kpos)))) : '0;
                sh_kpos = sh_kpos + 1'b1;
                if (sh_len_left != '0)
                    sh_len_left = sh_len_left - 1'b1;
                last = (sh_len_left == '0);
                push_word(b ^ kbyte, 1'b1, last);
                if (last)
                    sh_phase = PH_HDR0;
            end
            default:
            begin
                sh_phase = PH_HDR0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one stream byte, after a random gap if idle_on is set; returns at the accepting edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_deframe(b);
        bytes_sent++;
    endtask

    // Drop valid and wait until every owed word has come out.
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_header(input logic [BYTE_W-1:0] hdr0, input logic masked,
                               input logic [LEN_W-1:0] len, input int form,
                               input logic [KEY_W-1:0] key);
        send_byte(hdr0);
        case (form)
            FORM_EXT16:
            begin
                send_byte({masked, LEN_CODE_16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            FORM_EXT64:
            begin
                send_byte({masked, LEN_CODE_64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
            default:
            begin
                send_byte({masked, len[6:0]});
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8*i +: 8]);
    endtask

    task automatic send_payload(input int n);
        for (int i = 0; i < n; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] hdr0, input logic masked,
                              input logic [LEN_W-1:0] len, input int form,
                              input logic [KEY_W-1:0] key);
        send_header(hdr0, masked, len, form, key);
        send_payload(int'(len));
    endtask

    // Random frame: any first byte (reserved bits, odd opcodes), flagged
    // opcodes favored, all three length encodings, short lengths mostly.
    task automatic send_random_frame();
        logic [BYTE_W-1:0] hdr0;
        logic              masked;
        logic [LEN_W-1:0]  len;
        int                form;
        int                pick;
        hdr0 = BYTE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0: hdr0[3:0] = OP_CONT;
            1: hdr0[3:0] = OP_CLOSE;
            2: hdr0[3:0] = OP_PING;
            default: ;
        endcase
        masked = 1'($urandom_range(0, 1));
        pick   = $urandom_range(0, 19);
        if (pick < 12)
        begin
            form = FORM_SHORT;
            len  = LEN_W'($urandom_range(0, 20));
        end
        else if (pick == 12)
        begin
            form = FORM_SHORT;
            len  = 125;
        end
        else if (pick < 17)
        begin
            form = FORM_EXT16;
            len  = LEN_W'($urandom_range(0, 24));
        end
        else
        begin
            form = FORM_EXT64;
            len  = LEN_W'($urandom_range(0, 16));
        end
        send_frame(hdr0, masked, len, form, KEY_W'($urandom));
    endtask

    // Receiver hold-off, counted on rising edges so the stall driver
    // never sees it change at its own edge.
    task automatic hold_receiver(input int cycles);
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_rx = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        idle_on = 1'b1;
        // empty close frame: flag-only word on the second header byte
        send_frame(8'h88, 1'b0, 0, FORM_SHORT, '0);
        // masked ping, one byte, all-ones key
        send_frame(8'h89, 1'b1, 1, FORM_SHORT, 32'hFFFF_FFFF);
        // non-final continuation with reserved bits set
        send_frame(8'h70, 1'b0, 1, FORM_SHORT, '0);
        // empty frame announced through the 16-bit length
        send_frame(8'h81, 1'b0, 0, FORM_EXT16, '0);
        // unknown opcode, 64-bit length of one
        send_frame(8'h8F, 1'b0, 1, FORM_EXT64, '0);
        wait_drain();
    endtask

    task automatic test_length_boundaries();
        idle_on = 1'b1;
        send_frame(8'h82, 1'b1, 125, FORM_SHORT, KEY_W'($urandom));
        send_frame(8'h02, 1'b0, 126, FORM_EXT16, '0);
        // borrow across the low length byte
        send_frame(8'h81, 1'b1, 256, FORM_EXT16, KEY_W'($urandom));
        // masked empty frame: flag-only word after the key
        send_frame(8'h89, 1'b1, 0, FORM_EXT64, KEY_W'($urandom));
        wait_drain();
    endtask

    task automatic test_backpressure();
        idle_on = 1'b1;
        // receiver blocked long enough for the block to fill and stall input
        fork
            hold_receiver(HOLD_CYCLES);
            send_frame(8'h82, 1'b1, 90, FORM_SHORT, KEY_W'($urandom));
        join
        wait_drain();
    endtask

    task automatic test_truncated_frame();
        idle_on = 1'b1;
        // stream dries up mid-payload; the block must just wait
        send_header(8'h81, 1'b1, 12, FORM_SHORT, KEY_W'($urandom));
        send_payload(5);
        wait_drain();
        send_payload(7);
        // and again inside the extended length
        send_byte(8'h08);
        send_byte({1'b0, LEN_CODE_16});
        send_byte(8'h00);
        wait_drain();
        send_byte(8'h03);
        send_payload(3);
        wait_drain();
    endtask

    task automatic test_random_frames(input int target);
        idle_on = 1'b1;
        while (bytes_sent < target)
            send_random_frame();
        wait_drain();
    endtask

    task automatic test_back_to_back(input int target);
        idle_on = 1'b0;
        while (bytes_sent < target)
            send_random_frame();
        wait_drain();
    endtask

    // 64-bit length with the top bit set never ends, so this runs last.
    task automatic test_huge_length();
        idle_on = 1'b1;
        send_header(8'h82, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, FORM_EXT64, KEY_W'($urandom));
        send_payload(30);
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver side and checking
    // ------------------------------------------------------------------

    always @(negedge clk)
        out_stall <= hold_rx || (stall_left != 0);

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual byte %0h end %0b",
                         $time, out_byte, frame_end);
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("out_byte", want.data, out_byte);
                check_field("data_valid", BYTE_W'(want.data_valid), BYTE_W'(data_valid));
                check_field("is_final", BYTE_W'(want.is_final), BYTE_W'(is_final));
                check_field("is_ping", BYTE_W'(want.is_ping), BYTE_W'(is_ping));
                check_field("is_continuation", BYTE_W'(want.is_continuation),
                            BYTE_W'(is_continuation));
                check_field("is_close", BYTE_W'(want.is_close), BYTE_W'(is_close));
                check_field("frame_end", BYTE_W'(want.frame_end), BYTE_W'(frame_end));
            end
            stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
        end
    end

    // hang detector: any accepted word on either side restarts the count
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_length_boundaries();
        test_backpressure();
        test_truncated_frame();
        test_random_frames(1300);
        test_back_to_back(1510);
        test_huge_length();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
